FILE: hdl/scdht_pkg.sv
`timescale 1ns / 1ps
package scdht_pkg;

  // Table geometry.
  localparam int TableSlots = 103;
  localparam int MaxWordLen = 29;
  localparam int LetterW    = 5;
  localparam int SlotW      = 7;
  localparam int LenW       = 5;
  localparam int RowW       = LenW + MaxWordLen * LetterW;

  // Hash constants.
  localparam int Base1  = 31;
  localparam int Mod1   = 103;
  localparam int Base2  = 29;
  localparam int Mod2   = 101;
  localparam int Step   = 97;
  localparam int Alpha  = 26;

  // Verdict codes.
  localparam logic [1:0] VerdictFound   = 2'd0;
  localparam logic [1:0] VerdictNear    = 2'd1;
  localparam logic [1:0] VerdictUnknown = 2'd2;

  // Remainder by 103 of a value below 4096, by reciprocal multiply and one correction.
  function automatic logic [6:0] mod103(input logic [11:0] x);
    logic [21:0] p;
    logic [11:0] q;
    logic [11:0] r;
    p = 22'(x) * 22'(636);
    q = 12'(p >> 16);
    r = x - 12'(q * 12'(Mod1));
    if (r >= 12'(Mod1)) r = r - 12'(Mod1);
    return r[6:0];
  endfunction

  // Remainder by 101 of a value below 4096.
  function automatic logic [6:0] mod101(input logic [11:0] x);
    logic [21:0] p;
    logic [11:0] q;
    logic [11:0] r;
    p = 22'(x) * 22'(648);
    q = 12'(p >> 16);
    r = x - 12'(q * 12'(Mod2));
    if (r >= 12'(Mod2)) r = r - 12'(Mod2);
    return r[6:0];
  endfunction

endpackage

FILE: hdl/spell_check_double_hash_table.sv
`timescale 1ns / 1ps
// A dictionary word is hashed and stored once its last letter (of L letters) has been taken.
// A query first tries the exact word and otherwise walks up to about 1600 edit candidates,
// each hashed and probed in turn through the single row port of the slot memory.
// Throughput: one word at a time; letters are taken one per cycle while the block is idle.
// Reset: asynchronous, active low; all slots read as empty and the letter count is cleared.
module spell_check_double_hash_table
  import scdht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [4:0] letter_i,
  input  logic       last_letter_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CAND, S_HASH, S_PROBE, S_STORE, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    M_STORE, M_EXACT, M_DEL, M_INS, M_SUB
  } mode_e;

  state_e state_q;
  mode_e  mode_q, adv_mode;
  logic [4:0] pos_q, adv_pos;
  logic [4:0] chr_q, adv_chr;
  logic [4:0] wlen_q, wlen_new;
  logic [4:0] n_q;
  logic [5:0] hcnt_q;
  logic [6:0] acc1_q, acc2_q;
  logic [6:0] h2_q, idx_q, idx_step;
  logic [6:0] pcnt_q;
  logic       cmp_en_q, rd_vld_q;
  logic [TableSlots-1:0] slot_vld_q;
  logic [1:0] verdict_q, result_q;
  logic       out_valid_q;
  logic       in_acc;

  logic [LetterW-1:0] wbuf_q [MaxWordLen];
  logic [LetterW-1:0] upper [MaxWordLen];
  logic [LetterW-1:0] lower [MaxWordLen];
  logic [LetterW-1:0] cand [MaxWordLen];
  logic [5:0]         cand_len;
  logic [RowW-1:0]    row_mem [TableSlots];
  logic [RowW-1:0]    rdata_q, row_wdata;
  logic               row_we, hit;
  logic [LetterW-1:0] hlet;
  logic [7:0]         idx_sum;
  logic [6:0]         acc2_r;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign wlen_new    = (wlen_q < 5'(MaxWordLen)) ? wlen_q + 5'd1 : wlen_q;

  // Shifted views of the word buffer for deletions and insertions.
  always_comb begin
    for (int k = 0; k < MaxWordLen - 1; k++) begin
      upper[k]     = wbuf_q[k+1];
      lower[k+1]   = wbuf_q[k];
    end
    upper[MaxWordLen-1] = '0;
    lower[0]            = '0;
  end

  // Candidate word for the current edit.
  always_comb begin
    for (int k = 0; k < MaxWordLen; k++) begin
      case (mode_q)
        M_DEL:   cand[k] = (5'(k) < pos_q) ? wbuf_q[k] : upper[k];
        M_INS: begin
          if (5'(k) < pos_q)       cand[k] = wbuf_q[k];
          else if (5'(k) == pos_q) cand[k] = chr_q;
          else                     cand[k] = lower[k];
        end
        M_SUB:   cand[k] = (5'(k) == pos_q) ? chr_q : wbuf_q[k];
        default: cand[k] = wbuf_q[k];
      endcase
    end
    case (mode_q)
      M_DEL:   cand_len = {1'b0, n_q} - 6'd1;
      M_INS:   cand_len = {1'b0, n_q} + 6'd1;
      default: cand_len = {1'b0, n_q};
    endcase
  end

  // Next edit in enumeration order.
  always_comb begin
    adv_mode = mode_q;
    adv_pos  = pos_q;
    adv_chr  = chr_q;
    case (mode_q)
      M_EXACT: begin
        adv_mode = M_DEL;
        adv_pos  = '0;
      end
      M_DEL:   adv_pos = pos_q + 5'd1;
      M_INS, M_SUB: begin
        if (chr_q == 5'(Alpha)) begin
          adv_chr = 5'd1;
          adv_pos = pos_q + 5'd1;
        end else begin
          adv_chr = chr_q + 5'd1;
        end
      end
      default: ;
    endcase
  end

  // Hash input letter, probe step and row compare.
  assign hlet     = cand[5'(hcnt_q - 6'd1)];
  assign idx_sum  = {1'b0, idx_q} + {1'b0, h2_q};
  assign idx_step = (idx_sum >= 8'(TableSlots)) ? 7'(idx_sum - 8'(TableSlots)) : idx_sum[6:0];
  assign acc2_r   = (acc2_q >= 7'(Step)) ? acc2_q - 7'(Step) : acc2_q;

  always_comb begin
    hit = cmp_en_q && rd_vld_q && (rdata_q[RowW-1 -: LenW] == cand_len[4:0]);
    for (int k = 0; k < MaxWordLen; k++) begin
      if ((6'(k) < cand_len) && (rdata_q[k*LetterW +: LetterW] != cand[k])) hit = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < MaxWordLen; k++) row_wdata[k*LetterW +: LetterW] = cand[k];
    row_wdata[RowW-1 -: LenW] = n_q;
  end

  assign row_we = (state_q == S_STORE) && (pcnt_q < 7'(TableSlots)) && !slot_vld_q[idx_q];

  // Slot row memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[idx_q] <= row_wdata;
    rdata_q <= row_mem[idx_q];
  end

  // Word buffer capture.
  always_ff @(posedge clk_i) begin
    if (in_acc && (wlen_q < 5'(MaxWordLen))) wbuf_q[wlen_q] <= letter_i;
  end

  // Sequencer: receive, enumerate candidates, hash, probe, store, report.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_EXACT;
      pos_q       <= '0;
      chr_q       <= 5'd1;
      wlen_q      <= '0;
      n_q         <= '0;
      hcnt_q      <= '0;
      acc1_q      <= '0;
      acc2_q      <= '0;
      h2_q        <= 7'd1;
      idx_q       <= '0;
      pcnt_q      <= '0;
      cmp_en_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      slot_vld_q  <= '0;
      result_q    <= VerdictUnknown;
      verdict_q   <= VerdictUnknown;
      out_valid_q <= 1'b0;
    end else begin
      // The report state loads the output word itself.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            wlen_q <= last_letter_i ? '0 : wlen_new;
            if (last_letter_i) begin
              n_q    <= wlen_new;
              pos_q  <= '0;
              chr_q  <= 5'd1;
              if (action_i) begin
                mode_q  <= M_EXACT;
                state_q <= S_CAND;
              end else begin
                mode_q  <= M_STORE;
                acc1_q  <= '0;
                acc2_q  <= '0;
                hcnt_q  <= {1'b0, wlen_new};
                state_q <= S_HASH;
              end
            end
          end
        end
        S_CAND: begin
          if (mode_q == M_DEL && pos_q >= n_q) begin
            mode_q <= M_INS;
            pos_q  <= '0;
            chr_q  <= 5'd1;
          end else if (mode_q == M_INS && pos_q > n_q) begin
            mode_q <= M_SUB;
            pos_q  <= '0;
            chr_q  <= 5'd1;
          end else if (mode_q == M_SUB && pos_q >= n_q) begin
            result_q <= VerdictUnknown;
            state_q  <= S_DONE;
          end else if (cand_len == 6'd0 || cand_len > 6'(MaxWordLen)) begin
            mode_q <= adv_mode;
            pos_q  <= adv_pos;
            chr_q  <= adv_chr;
          end else begin
            acc1_q  <= '0;
            acc2_q  <= '0;
            hcnt_q  <= cand_len;
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          if (hcnt_q != 6'd0) begin
            acc1_q <= mod103(12'(acc1_q) * 12'(Base1) + 12'(hlet));
            acc2_q <= mod101(12'(acc2_q) * 12'(Base2) + 12'(hlet));
            hcnt_q <= hcnt_q - 6'd1;
          end else begin
            idx_q    <= acc1_q;
            h2_q     <= 7'(Step) - acc2_r;
            pcnt_q   <= '0;
            cmp_en_q <= 1'b0;
            if (mode_q == M_STORE) begin
              state_q <= (n_q == 5'd0) ? S_IDLE : S_STORE;
            end else begin
              state_q <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          // One read issued per cycle; the previous probe is compared.
          rd_vld_q <= slot_vld_q[idx_q];
          if (pcnt_q < 7'(TableSlots)) begin
            idx_q  <= idx_step;
            pcnt_q <= pcnt_q + 7'd1;
          end
          if (hit) begin
            result_q <= (mode_q == M_EXACT) ? VerdictFound : VerdictNear;
            cmp_en_q <= 1'b0;
            state_q  <= S_DONE;
          end else if (pcnt_q == 7'(TableSlots)) begin
            cmp_en_q <= 1'b0;
            mode_q   <= adv_mode;
            pos_q    <= adv_pos;
            chr_q    <= adv_chr;
            state_q  <= S_CAND;
          end else begin
            cmp_en_q <= (pcnt_q < 7'(TableSlots));
          end
        end
        S_STORE: begin
          if (pcnt_q == 7'(TableSlots)) begin
            state_q <= S_IDLE;
          end else if (!slot_vld_q[idx_q]) begin
            slot_vld_q[idx_q] <= 1'b1;
            state_q           <= S_IDLE;
          end else begin
            idx_q  <= idx_step;
            pcnt_q <= pcnt_q + 7'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            verdict_q   <= result_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The probe step is never zero, so every slot of the walk is distinct.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_STORE) |-> (h2_q != 7'd0 && h2_q <= 7'(Step)))
    else $error("probe step out of range");
  // Slot index stays inside the table during walks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_STORE) |-> (idx_q < 7'(TableSlots)))
    else $error("slot index out of range");
  // The probe counter never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= 7'(TableSlots))
    else $error("probe counter overrun");
  // A new result only comes from the report state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside report state");
`endif

endmodule
